/* rtl/brl_pkg.sv */
`timescale 1ns / 1ps

package brl_pkg;

  // Coordinate width of every endpoint and pixel
  localparam int unsigned CoordBits = 12;
  // Axis distances need one bit more than a coordinate
  localparam int unsigned DistBits  = CoordBits + 1;
  // Error term stays below twice the major distance
  localparam int unsigned ErrBits   = CoordBits + 2;

  // Operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpStep = 1'b1;

  typedef struct packed {
    logic                        operation;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } brl_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pixel_x;
    logic signed [CoordBits-1:0] pixel_y;
    logic                        last;
    logic                        valid_res;
  } brl_out_t;

  // Line parameters set up on load and walked on each step
  typedef struct packed {
    logic [DistBits-1:0] major;
    logic [DistBits-1:0] minor;
    logic [ErrBits-1:0]  err;
    logic [DistBits-1:0] left;
    logic                x_neg;
    logic                y_neg;
    logic                x_major;
  } brl_line_t;

endpackage

/* rtl/brl_setup.sv */
`timescale 1ns / 1ps

module brl_setup (
  input  brl_pkg::brl_in_t   item_i,
  output brl_pkg::brl_line_t line_o
);

  logic signed [brl_pkg::DistBits-1:0] dx;
  logic signed [brl_pkg::DistBits-1:0] dy;
  logic        [brl_pkg::DistBits-1:0] abs_x;
  logic        [brl_pkg::DistBits-1:0] abs_y;
  logic                                x_major;
  logic        [brl_pkg::DistBits-1:0] major;

  // Take endpoint differences with one guard bit
  assign dx = brl_pkg::DistBits'(item_i.end_x) - brl_pkg::DistBits'(item_i.start_x);
  assign dy = brl_pkg::DistBits'(item_i.end_y) - brl_pkg::DistBits'(item_i.start_y);

  // Fold to magnitudes; a zero difference walks in the positive direction
  assign abs_x = dx[brl_pkg::DistBits-1] ? brl_pkg::DistBits'(-dx) : dx;
  assign abs_y = dy[brl_pkg::DistBits-1] ? brl_pkg::DistBits'(-dy) : dy;

  // Pick the major axis, x on a tie
  assign x_major = !(abs_x < abs_y);
  assign major   = x_major ? abs_x : abs_y;

  assign line_o.major   = major;
  assign line_o.minor   = x_major ? abs_y : abs_x;
  assign line_o.err     = brl_pkg::ErrBits'(major >> 1);
  assign line_o.left    = major;
  assign line_o.x_neg   = dx[brl_pkg::DistBits-1];
  assign line_o.y_neg   = dy[brl_pkg::DistBits-1];
  assign line_o.x_major = x_major;

endmodule

/* rtl/brl_walk.sv */
`timescale 1ns / 1ps

module brl_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  brl_pkg::brl_in_t   item_i,
  input  brl_pkg::brl_line_t setup_i,
  output brl_pkg::brl_out_t  res_o
);

  brl_pkg::brl_line_t                   line_q, line_d;
  logic signed [brl_pkg::CoordBits-1:0] cur_x_q, cur_x_d;
  logic signed [brl_pkg::CoordBits-1:0] cur_y_q, cur_y_d;
  logic                                 active_q, active_d;

  logic [brl_pkg::ErrBits-1:0]          err_sum;
  logic                                 diag;
  logic                                 move_x;
  logic                                 move_y;
  logic                                 last;

  // Advance the error term by the minor distance and test for a diagonal move
  assign err_sum = line_q.err + brl_pkg::ErrBits'(line_q.minor);
  assign diag    = err_sum >= brl_pkg::ErrBits'(line_q.major);
  assign move_x  = diag || line_q.x_major;
  assign move_y  = diag || !line_q.x_major;

  // Emit the current transaction's pixel and form the next line state
  always_comb begin
    line_d   = line_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    active_d = active_q;
    last     = 1'b0;
    res_o    = '0;
    if (item_i.operation == brl_pkg::OpLoad) begin
      line_d    = setup_i;
      cur_x_d   = item_i.start_x;
      cur_y_d   = item_i.start_y;
      last      = (setup_i.major == '0);
      active_d  = !last;
      res_o.pixel_x   = item_i.start_x;
      res_o.pixel_y   = item_i.start_y;
      res_o.last      = last;
      res_o.valid_res = 1'b1;
    end else if (active_q) begin
      line_d.err  = diag ? err_sum - brl_pkg::ErrBits'(line_q.major) : err_sum;
      line_d.left = line_q.left - brl_pkg::DistBits'(1);
      if (move_x) begin
        cur_x_d = line_q.x_neg ? cur_x_q - brl_pkg::CoordBits'(1)
                               : cur_x_q + brl_pkg::CoordBits'(1);
      end
      if (move_y) begin
        cur_y_d = line_q.y_neg ? cur_y_q - brl_pkg::CoordBits'(1)
                               : cur_y_q + brl_pkg::CoordBits'(1);
      end
      last      = (line_q.left == brl_pkg::DistBits'(1));
      active_d  = !last;
      res_o.pixel_x   = cur_x_d;
      res_o.pixel_y   = cur_y_d;
      res_o.last      = last;
      res_o.valid_res = 1'b1;
    end
  end

  // Hold the line state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      active_q <= 1'b0;
    end else if (fire_i) begin
      line_q   <= line_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      active_q <= active_d;
    end
  end

endmodule

/* rtl/bresenham_line_rasterizer_unit.sv */
`timescale 1ns / 1ps

// Bresenham line rasterizer. A load transaction (operation 0) takes two signed
// endpoints and returns the start pixel; each step transaction (operation 1)
// returns the next pixel of the line, with last set on the final one. A step
// with no line in progress returns valid_res 0 and zero fields. One transaction
// is accepted every cycle while the output is taken, and each produces exactly
// one result. The item is held in an input register, and the setup (or the
// add-and-compare of one walk step) runs between that register and the result
// register, which drives the output. The line state updates as the result is
// captured. While a result waits, one more transaction can still enter the
// input register; in_ready_o drops only when both registers are full.
module bresenham_line_rasterizer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brl_pkg::brl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brl_pkg::brl_out_t out_data_o
);

  logic               in_valid_q;
  brl_pkg::brl_in_t   in_q;
  logic               out_valid_q;
  brl_pkg::brl_out_t  out_q;
  logic               fire;
  brl_pkg::brl_line_t setup;
  brl_pkg::brl_out_t  res;

  // Move the held item to the result register when that register frees up
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  brl_setup u_setup (
    .item_i (in_q),
    .line_o (setup)
  );

  brl_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .setup_i (setup),
    .res_o   (res)
  );

  // Capture incoming transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
